FILE: rtl/ter_pkg.sv
// Shared constants and widths for the tensor extrapolation realizability block.
package ter_pkg;
    localparam int NUM_COMP  = 10;
    localparam int IDX_W     = 4;
    localparam int VAL_W     = 32;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = 32;
    localparam int NUM_W     = 60;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 66;
    localparam int ACC_W     = 100;
    localparam int ADDR_W    = 3;

    localparam logic [IDX_W-1:0] COMP_CHI = 4'd0;
    localparam logic [IDX_W-1:0] COMP_X   = 4'd1;
    localparam logic [IDX_W-1:0] COMP_A   = 4'd4;
    localparam logic [IDX_W-1:0] COMP_B   = 4'd5;
    localparam logic [IDX_W-1:0] COMP_C   = 4'd6;
    localparam logic [IDX_W-1:0] COMP_D   = 4'd7;
    localparam logic [IDX_W-1:0] COMP_E   = 4'd8;
    localparam logic [IDX_W-1:0] COMP_F   = 4'd9;
    localparam logic [IDX_W-1:0] COMP_LAST = 4'd9;

    localparam logic REG_RATIO = 1'b0;
    localparam logic REG_FULL  = 1'b1;

    localparam logic signed [VAL_W-1:0] Q_ONE     = 32'sh1000_0000;
    localparam logic [ROOT_W-1:0]       NORM_MIN  = 32'h0800_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN   = 32'sh8000_0000;
    localparam logic [VAL_W-1:0]        CNT_MAX   = 32'hFFFF_FFFF;
endpackage

FILE: rtl/ter_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module ter_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ter_pkg::SQ_W-1:0]    i_radicand,
    output logic                        o_done,
    output logic [ter_pkg::ROOT_W-1:0]  o_root
);
    import ter_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [4:0]        r_cnt, n_cnt;
    logic [SQ_W-1:0]   r_rem, n_rem;
    logic [SQ_W-1:0]   r_res, n_res;
    logic [SQ_W-1:0]   r_bit, n_bit;
    logic [SQ_W-1:0]   trial;

    assign trial = r_res + r_bit;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_res  = r_res;
        n_bit  = r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_radicand;
            n_res  = '0;
            n_bit  = {2'b01, {(SQ_W-2){1'b0}}};
        end else if (r_busy) begin
            if (r_rem >= trial) begin
                n_rem = r_rem - trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];
endmodule

FILE: rtl/ter_div.sv
// Restoring divider, one quotient bit per cycle.
module ter_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ter_pkg::NUM_W-1:0]   i_num,
    input  logic [ter_pkg::ROOT_W-1:0]  i_den,
    output logic                        o_done,
    output logic [ter_pkg::NUM_W-1:0]   o_quot
);
    import ter_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [5:0]        r_cnt, n_cnt;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [ROOT_W:0]   r_rem, n_rem;
    logic [ROOT_W-1:0] r_den, n_den;
    logic [ROOT_W:0]   rem_sh;
    logic              q_bit;

    assign rem_sh = {r_rem[ROOT_W-1:0], r_num[NUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem = q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
            n_num = {r_num[NUM_W-2:0], q_bit};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'(NUM_W-1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_num;
endmodule

FILE: rtl/tensor_extrapolate_realizability.sv
// Top level: component stores, evaluation sequencer, shared multiplier, output register.
// Steps after the completing item: extrapolate, sum of squares, bit-serial square root,
// three bit-serial divides, tensor checks in full mode only, decide and emit; an early
// reject goes straight to decide. Throughput: one item per cycle while collecting,
// stalled while a cell is evaluated and emitted, one result at a time and held while the
// output is stalled. Reset clears sequencer, mask, counter; stores need none.
module tensor_extrapolate_realizability (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ter_pkg::IDX_W-1:0]     i_component,
    input  logic signed [ter_pkg::VAL_W-1:0] i_older_value,
    input  logic signed [ter_pkg::VAL_W-1:0] i_newer_value,
    input  logic                          i_active_cell,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ter_pkg::IDX_W-1:0]     o_out_component,
    output logic signed [ter_pkg::VAL_W-1:0] o_out_value,
    output logic                          o_rejected,
    output logic                          o_last_of_cell,
    output logic [ter_pkg::VAL_W-1:0]     o_reject_total,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ter_pkg::ADDR_W-1:0]    paddr,
    input  logic [ter_pkg::VAL_W-1:0]     pwdata,
    output logic [ter_pkg::VAL_W-1:0]     prdata,
    output logic                          pready
);
    import ter_pkg::*;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_EX_RD     = 5'd1;
    localparam logic [4:0] S_EX_MUL    = 5'd2;
    localparam logic [4:0] S_EX_ADD    = 5'd3;
    localparam logic [4:0] S_SQ_MUL    = 5'd4;
    localparam logic [4:0] S_SQ_ACC    = 5'd5;
    localparam logic [4:0] S_SQRT_GO   = 5'd6;
    localparam logic [4:0] S_SQRT_WAIT = 5'd7;
    localparam logic [4:0] S_NORM_GO   = 5'd8;
    localparam logic [4:0] S_NORM_WAIT = 5'd9;
    localparam logic [4:0] S_DIAG      = 5'd10;
    localparam logic [4:0] S_MIN_AB    = 5'd11;
    localparam logic [4:0] S_MIN_DD    = 5'd12;
    localparam logic [4:0] S_MIN_CHK   = 5'd13;
    localparam logic [4:0] S_DT_XY     = 5'd14;
    localparam logic [4:0] S_DT_LO     = 5'd15;
    localparam logic [4:0] S_DT_HI     = 5'd16;
    localparam logic [4:0] S_DT_ACC    = 5'd17;
    localparam logic [4:0] S_DECIDE    = 5'd18;
    localparam logic [4:0] S_EM_RD     = 5'd19;
    localparam logic [4:0] S_EM_OUT    = 5'd20;

    localparam logic [NUM_COMP-1:0] MASK_FULL = {NUM_COMP{1'b1}};

    // configuration
    logic signed [VAL_W-1:0] r_ratio;
    logic                    r_full;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= '0;
            r_full  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_RATIO: r_ratio <= pwdata;
                REG_FULL:  r_full  <= pwdata[0];
                default:   r_full  <= r_full;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RATIO: prdata = r_ratio;
            REG_FULL:  prdata = {{(VAL_W-1){1'b0}}, r_full};
            default:   prdata = '0;
        endcase
    end

    // sequencer registers
    logic [4:0]              r_state, n_state;
    logic [IDX_W-1:0]        r_k, n_k;
    logic [2:0]              r_t, n_t;
    logic [NUM_COMP-1:0]     r_mask, n_mask;
    logic                    r_active, n_active;
    logic                    r_ok, n_ok;
    logic [VAL_W-1:0]        r_cnt, n_cnt;
    logic signed [VAL_W-1:0] r_ds [NUM_COMP];
    logic [SQ_W-1:0]         r_sum, n_sum;
    logic [ROOT_W-1:0]       r_nn, n_nn;
    logic signed [SQ_W-1:0]  r_ab, n_ab;
    logic signed [SQ_W-1:0]  r_p, n_p;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [PROD_W-1:0] r_prod;

    // output register
    logic                    r_o_valid, n_o_valid;
    logic [IDX_W-1:0]        r_o_comp, n_o_comp;
    logic signed [VAL_W-1:0] r_o_value, n_o_value;
    logic                    r_o_rej, n_o_rej;
    logic                    r_o_last, n_o_last;
    logic [VAL_W-1:0]        r_o_total, n_o_total;

    // stores
    logic [VAL_W-1:0]        older_mem [NUM_COMP];
    logic [VAL_W-1:0]        newer_mem [NUM_COMP];
    logic signed [VAL_W-1:0] r_old_q, r_new_q;
    logic                    in_acc, in_ok;

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid & ~o_stall;
    assign in_ok   = in_acc & (i_component < IDX_W'(NUM_COMP));

    always_ff @(posedge i_clk) begin
        if (in_ok) begin
            older_mem[i_component] <= i_older_value;
            newer_mem[i_component] <= i_newer_value;
        end
        r_old_q <= older_mem[r_k];
        r_new_q <= newer_mem[r_k];
    end

    // shared multiplier
    logic signed [MUL_W-1:0] mul_x, mul_y;
    logic [IDX_W-1:0]        sel_x, sel_y, sel_q;
    logic                    term_neg;

    always_comb begin
        sel_x    = COMP_A;
        sel_y    = COMP_B;
        sel_q    = COMP_C;
        term_neg = 1'b0;
        case (r_t)
            3'd0: begin sel_x = COMP_A; sel_y = COMP_B; sel_q = COMP_C; term_neg = 1'b0; end
            3'd1: begin sel_x = COMP_A; sel_y = COMP_F; sel_q = COMP_F; term_neg = 1'b1; end
            3'd2: begin sel_x = COMP_D; sel_y = COMP_D; sel_q = COMP_C; term_neg = 1'b1; end
            3'd3: begin sel_x = COMP_D; sel_y = COMP_E; sel_q = COMP_F; term_neg = 1'b0; end
            3'd4: begin sel_x = COMP_D; sel_y = COMP_E; sel_q = COMP_F; term_neg = 1'b0; end
            3'd5: begin sel_x = COMP_B; sel_y = COMP_E; sel_q = COMP_E; term_neg = 1'b1; end
            default: begin sel_x = COMP_A; sel_y = COMP_B; sel_q = COMP_C; term_neg = 1'b0; end
        endcase
    end

    logic signed [VAL_W-1:0] sq_v;
    assign sq_v = r_ds[COMP_X + IDX_W'(r_t)];

    always_comb begin
        mul_x = '0;
        mul_y = '0;
        case (r_state)
            S_EX_MUL: begin
                mul_x = MUL_W'(r_ratio);
                mul_y = MUL_W'(r_new_q) - MUL_W'(r_old_q);
            end
            S_SQ_MUL: begin
                mul_x = MUL_W'(sq_v);
                mul_y = MUL_W'(sq_v);
            end
            S_MIN_AB: begin
                mul_x = MUL_W'(r_ds[COMP_A]);
                mul_y = MUL_W'(r_ds[COMP_B]);
            end
            S_MIN_DD: begin
                mul_x = MUL_W'(r_ds[COMP_D]);
                mul_y = MUL_W'(r_ds[COMP_D]);
            end
            S_DT_XY: begin
                mul_x = MUL_W'(r_ds[sel_x]);
                mul_y = MUL_W'(r_ds[sel_y]);
            end
            S_DT_LO: begin
                mul_x = $signed({1'b0, r_prod[VAL_W-1:0]});
                mul_y = MUL_W'(r_ds[sel_q]);
            end
            S_DT_HI: begin
                mul_x = MUL_W'($signed(r_p[SQ_W-1:VAL_W]));
                mul_y = MUL_W'(r_ds[sel_q]);
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_x * mul_y;
    end

    // extrapolation rounding and saturation
    logic signed [PROD_W-1:0] ex_rnd, ex_sum;
    logic signed [VAL_W-1:0]  ex_val;

    assign ex_rnd = (r_prod + PROD_W'(32768)) >>> 16;
    assign ex_sum = ex_rnd + PROD_W'(r_new_q);

    always_comb begin
        if (ex_sum > PROD_W'(VAL_MAX))      ex_val = VAL_MAX;
        else if (ex_sum < PROD_W'(VAL_MIN)) ex_val = VAL_MIN;
        else                                ex_val = ex_sum[VAL_W-1:0];
    end

    // square root and divider
    logic              sqrt_start, sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quot;
    logic [VAL_W-1:0]  nv_mag;
    logic signed [VAL_W-1:0] nv_val;

    assign sqrt_start = (r_state == S_SQRT_GO);
    assign div_start  = (r_state == S_NORM_GO);
    assign nv_mag     = sq_v[VAL_W-1] ? (VAL_W'(0) - VAL_W'(sq_v)) : VAL_W'(sq_v);
    assign div_num    = ({{(NUM_W-VAL_W){1'b0}}, nv_mag} << 28)
                      + {{(NUM_W-ROOT_W+1){1'b0}}, r_nn[ROOT_W-1:1]};

    ter_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_sum),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    ter_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_nn),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        if (sq_v[VAL_W-1]) begin
            if (div_quot > NUM_W'(33'h1_0000_0000 >> 1)) nv_val = VAL_MIN;
            else nv_val = VAL_W'(0) - div_quot[VAL_W-1:0];
        end else begin
            if (div_quot > NUM_W'(VAL_MAX)) nv_val = VAL_MAX;
            else nv_val = div_quot[VAL_W-1:0];
        end
    end

    // checks and determinant terms
    logic chi_ok, diag_ok;
    logic signed [ACC_W-1:0] term_lo, term_hi;

    assign chi_ok  = (r_ds[COMP_CHI] >= 0) && (r_ds[COMP_CHI] <= Q_ONE);
    assign diag_ok = (r_ds[COMP_A] >= 0) && (r_ds[COMP_A] <= Q_ONE)
                  && (r_ds[COMP_B] >= 0) && (r_ds[COMP_B] <= Q_ONE)
                  && (r_ds[COMP_C] >= 0) && (r_ds[COMP_C] <= Q_ONE);
    assign term_lo = term_neg ? -ACC_W'(r_prod) : ACC_W'(r_prod);
    assign term_hi = term_neg ? -(ACC_W'(r_prod) <<< 32) : (ACC_W'(r_prod) <<< 32);

    // sequencer
    logic                    ds_we;
    logic [IDX_W-1:0]        ds_wa;
    logic signed [VAL_W-1:0] ds_wd;
    logic                    out_free;

    assign out_free = ~r_o_valid | ~i_stall;

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_t       = r_t;
        n_mask    = r_mask;
        n_active  = r_active;
        n_ok      = r_ok;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_nn      = r_nn;
        n_ab      = r_ab;
        n_p       = r_p;
        n_acc     = r_acc;
        ds_we     = 1'b0;
        ds_wa     = r_k;
        ds_wd     = ex_val;
        n_o_valid = r_o_valid & i_stall;
        n_o_comp  = r_o_comp;
        n_o_value = r_o_value;
        n_o_rej   = r_o_rej;
        n_o_last  = r_o_last;
        n_o_total = r_o_total;
        unique case (r_state)
            S_IDLE: begin
                if (in_ok) begin
                    n_mask = r_mask | (NUM_COMP'(1) << i_component);
                    if (n_mask == MASK_FULL) begin
                        n_mask   = '0;
                        n_active = i_active_cell;
                        n_ok     = 1'b1;
                        n_k      = '0;
                        n_state  = S_EX_RD;
                    end
                end
            end
            S_EX_RD:  n_state = S_EX_MUL;
            S_EX_MUL: n_state = S_EX_ADD;
            S_EX_ADD: begin
                ds_we = 1'b1;
                if (r_k == COMP_LAST) begin
                    n_t     = '0;
                    n_sum   = '0;
                    n_state = S_SQ_MUL;
                end else begin
                    n_k     = r_k + IDX_W'(1);
                    n_state = S_EX_RD;
                end
            end
            S_SQ_MUL: n_state = S_SQ_ACC;
            S_SQ_ACC: begin
                n_sum = r_sum + r_prod[SQ_W-1:0];
                if (r_t == 3'd2) begin
                    n_state = S_SQRT_GO;
                end else begin
                    n_t     = r_t + 3'd1;
                    n_state = S_SQ_MUL;
                end
            end
            S_SQRT_GO: n_state = S_SQRT_WAIT;
            S_SQRT_WAIT: begin
                if (sqrt_done) begin
                    n_nn = sqrt_root;
                    n_t  = '0;
                    if (chi_ok && (sqrt_root > NORM_MIN)) begin
                        n_state = S_NORM_GO;
                    end else begin
                        n_ok    = 1'b0;
                        n_state = S_DECIDE;
                    end
                end
            end
            S_NORM_GO: n_state = S_NORM_WAIT;
            S_NORM_WAIT: begin
                if (div_done) begin
                    ds_we = 1'b1;
                    ds_wa = COMP_X + IDX_W'(r_t);
                    ds_wd = nv_val;
                    if (r_t == 3'd2) begin
                        n_state = r_full ? S_DIAG : S_DECIDE;
                    end else begin
                        n_t     = r_t + 3'd1;
                        n_state = S_NORM_GO;
                    end
                end
            end
            S_DIAG: begin
                if (diag_ok) begin
                    n_state = S_MIN_AB;
                end else begin
                    n_ok    = 1'b0;
                    n_state = S_DECIDE;
                end
            end
            S_MIN_AB: n_state = S_MIN_DD;
            S_MIN_DD: begin
                n_ab    = r_prod[SQ_W-1:0];
                n_state = S_MIN_CHK;
            end
            S_MIN_CHK: begin
                if (r_ab < $signed(r_prod[SQ_W-1:0])) begin
                    n_ok    = 1'b0;
                    n_state = S_DECIDE;
                end else begin
                    n_acc   = '0;
                    n_t     = '0;
                    n_state = S_DT_XY;
                end
            end
            S_DT_XY: n_state = S_DT_LO;
            S_DT_LO: begin
                n_p     = r_prod[SQ_W-1:0];
                n_state = S_DT_HI;
            end
            S_DT_HI: begin
                n_acc   = r_acc + term_lo;
                n_state = S_DT_ACC;
            end
            S_DT_ACC: begin
                n_acc = r_acc + term_hi;
                if (r_t == 3'd5) begin
                    n_state = S_DECIDE;
                end else begin
                    n_t     = r_t + 3'd1;
                    n_state = S_DT_XY;
                end
            end
            S_DECIDE: begin
                if (r_full && r_ok && n_acc[ACC_W-1]) n_ok = 1'b0;
                if (!n_ok && r_active && (r_cnt != CNT_MAX)) n_cnt = r_cnt + VAL_W'(1);
                n_k     = '0;
                n_state = S_EM_RD;
            end
            S_EM_RD: n_state = S_EM_OUT;
            S_EM_OUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_comp  = r_k;
                    n_o_value = r_ok ? r_ds[r_k] : r_new_q;
                    n_o_rej   = ~r_ok;
                    n_o_last  = (r_k == COMP_LAST);
                    n_o_total = r_cnt;
                    if (r_k == COMP_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = S_EM_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= '0;
            r_t       <= '0;
            r_mask    <= '0;
            r_active  <= 1'b0;
            r_ok      <= 1'b0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_t       <= n_t;
            r_mask    <= n_mask;
            r_active  <= n_active;
            r_ok      <= n_ok;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
        r_sum     <= n_sum;
        r_nn      <= n_nn;
        r_ab      <= n_ab;
        r_p       <= n_p;
        r_acc     <= n_acc;
        r_o_comp  <= n_o_comp;
        r_o_value <= n_o_value;
        r_o_rej   <= n_o_rej;
        r_o_last  <= n_o_last;
        r_o_total <= n_o_total;
        if (ds_we) r_ds[ds_wa] <= ds_wd;
    end

    assign o_valid         = r_o_valid;
    assign o_out_component = r_o_comp;
    assign o_out_value     = r_o_value;
    assign o_rejected      = r_o_rej;
    assign o_last_of_cell  = r_o_last;
    assign o_reject_total  = r_o_total;
endmodule

FILE: tb/tensor_extrapolate_realizability_tb.sv
// Self-checking testbench for tensor_extrapolate_realizability: directed table plus random cells.
module tensor_extrapolate_realizability_tb;
    import ter_pkg::*;

    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         SETTLE_CYCLES  = 400;
    localparam logic [1:0] PIN_PASS = 2'd0;
    localparam logic [1:0] PIN_REJ  = 2'd1;
    localparam logic [1:0] PIN_NONE = 2'd2;

    typedef struct {
        logic [IDX_W-1:0]        comp;
        logic signed [VAL_W-1:0] older;
        logic signed [VAL_W-1:0] newer;
        logic                    active;
        logic [1:0]              pin;
    } t_stim_row;

    typedef struct {
        logic [IDX_W-1:0]        comp;
        logic signed [VAL_W-1:0] value;
        logic                    rej;
        logic                    last;
        logic [VAL_W-1:0]        total;
        logic [1:0]              pin;
    } t_emit;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [IDX_W-1:0]        i_component = '0;
    logic signed [VAL_W-1:0] i_older_value = '0;
    logic signed [VAL_W-1:0] i_newer_value = '0;
    logic                    i_active_cell = 1'b0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [IDX_W-1:0]        o_out_component;
    logic signed [VAL_W-1:0] o_out_value;
    logic                    o_rejected;
    logic                    o_last_of_cell;
    logic [VAL_W-1:0]        o_reject_total;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [VAL_W-1:0]        pwdata = '0;
    logic [VAL_W-1:0]        prdata;
    logic                    pready;

    tensor_extrapolate_realizability dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    longint                  ratio_q16;
    logic                    full_mode;
    logic [VAL_W-1:0]        older_mem [NUM_COMP];
    logic [VAL_W-1:0]        newer_mem [NUM_COMP];
    logic [NUM_COMP-1:0]     have_mask;
    logic [VAL_W-1:0]        rejects_seen;

    t_emit                   pending_emits [$];
    int                      errors = 0;
    int                      cells_done = 0;
    int                      emits_checked = 0;
    int                      items_sent = 0;
    bit                      calm = 1'b0;
    int                      stall_left = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned res = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unit_scale(input longint v, input longint unsigned nn);
        longint unsigned mag = (v < 0) ? -v : v;
        longint unsigned q = ((mag << 28) + nn / 2) / nn;
        return sat32((v < 0) ? -longint'(q) : longint'(q));
    endfunction

    // stores one component; on cell completion queues the ten emitted components
    function automatic void absorb_component(input t_stim_row it);
        longint ds [NUM_COMP];
        longint d1, d0, prod;
        longint unsigned sumsq, nn;
        logic signed [127:0] ta, tb, tc, td, te, tf, det;
        bit ok;
        t_emit em;
        if (it.comp >= NUM_COMP) return;
        older_mem[it.comp] = it.older;
        newer_mem[it.comp] = it.newer;
        have_mask[it.comp] = 1'b1;
        if (have_mask != '1) return;
        have_mask = '0;
        for (int k = 0; k < NUM_COMP; k++) begin
            d1 = longint'($signed(newer_mem[k]));
            d0 = longint'($signed(older_mem[k]));
            prod = ratio_q16 * (d1 - d0);
            ds[k] = sat32(d1 + ((prod + 64'sd32768) >>> 16));
        end
        ok = ds[0] >= 0 && ds[0] <= Q_ONE;
        sumsq = ds[1] * ds[1] + ds[2] * ds[2] + ds[3] * ds[3];
        nn = int_sqrt(sumsq);
        ok = ok && nn > (64'd1 << 27);
        if (ok) begin
            for (int k = 1; k <= 3; k++) ds[k] = unit_scale(ds[k], nn);
        end
        if (full_mode) begin
            for (int k = COMP_A; k <= COMP_C; k++) ok = ok && ds[k] >= 0 && ds[k] <= Q_ONE;
            if (ok) begin
                ta = ds[COMP_A]; tb = ds[COMP_B]; tc = ds[COMP_C];
                td = ds[COMP_D]; te = ds[COMP_E]; tf = ds[COMP_F];
                det = ta*tb*tc - ta*tf*tf - td*td*tc + 2*td*te*tf - tb*te*te;
                ok = (ta*tb - td*td) >= 0 && det >= 0;
            end
        end
        if (!ok && it.active && rejects_seen != CNT_MAX) rejects_seen++;
        for (int k = 0; k < NUM_COMP; k++) begin
            em.comp  = IDX_W'(k);
            em.value = ok ? ds[k][31:0] : newer_mem[k];
            em.rej   = !ok;
            em.last  = (k == COMP_LAST);
            em.total = rejects_seen;
            em.pin   = it.pin;
            pending_emits.push_back(em);
        end
        cells_done++;
    endfunction

    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge i_clk) begin
        if (calm) begin
            stall_left = 0;
        end else if (stall_left == 0) begin
            if ($urandom_range(0, 99) < 2) stall_left = $urandom_range(8, 40);
            else if ($urandom_range(0, 99) < 30) stall_left = 1;
        end
        i_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
    end

    always @(posedge i_clk) begin
        t_emit w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_emits.size() == 0) begin
                report_mismatch("unexpected item, component", o_out_component, 0);
            end else begin
                w = pending_emits.pop_front();
                emits_checked++;
                if (o_out_component !== w.comp)
                    report_mismatch("out_component", o_out_component, w.comp);
                if (o_out_value !== w.value)
                    report_mismatch("out_value", o_out_value, w.value);
                if (o_rejected !== w.rej) report_mismatch("rejected", o_rejected, w.rej);
                if (w.pin != PIN_NONE && o_rejected !== w.pin[0])
                    report_mismatch("rejected (table)", o_rejected, w.pin[0]);
                if (o_last_of_cell !== w.last)
                    report_mismatch("last_of_cell", o_last_of_cell, w.last);
                if (o_reject_total !== w.total)
                    report_mismatch("reject_total", o_reject_total, w.total);
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d results still expected", pending_emits.size());
            $display("tensor_extrapolate_realizability_tb: errors");
            $finish;
        end
    end

    task automatic send_item(input t_stim_row it);
        int gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_component   = it.comp;
        i_older_value = it.older;
        i_newer_value = it.newer;
        i_active_cell = it.active;
        i_valid       = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        absorb_component(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [VAL_W-1:0] value);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {index, 2'b00}; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (index == REG_RATIO) ratio_q16 = longint'($signed(value));
        else full_mode = value[0];
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending_emits.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic signed [VAL_W-1:0] plausible(input int k);
        case (k)
            COMP_CHI: return $urandom_range(0, 99) < 85 ? $urandom_range(0, Q_ONE)
                                                        : $signed($urandom) >>> 2;
            1, 2, 3: return $signed($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
            COMP_A, COMP_B, COMP_C: return $urandom_range(0, Q_ONE);
            default: return $signed($urandom_range(0, Q_ONE / 4)) - Q_ONE / 8;
        endcase
    endfunction

    task automatic random_cell();
        int order [NUM_COMP];
        t_stim_row it;
        bit noisy = $urandom_range(0, 99) < 20;
        for (int k = 0; k < NUM_COMP; k++) order[k] = k;
        order.shuffle();
        for (int k = 0; k < NUM_COMP; k++) begin
            if ($urandom_range(0, 99) < 10) begin
                it.comp = IDX_W'($urandom_range(NUM_COMP, 15));
                it.older = $urandom; it.newer = $urandom;
                it.active = 1'($urandom_range(0, 1)); it.pin = PIN_NONE;
                send_item(it);
            end
            if ($urandom_range(0, 99) < 10 && k > 0) begin
                it.comp = IDX_W'(order[$urandom_range(0, k - 1)]);
                it.older = $urandom; it.newer = $urandom;
                it.active = 1'($urandom_range(0, 1)); it.pin = PIN_NONE;
                send_item(it);
            end
            it.comp = IDX_W'(order[k]);
            if (noisy || $urandom_range(0, 99) < 3) begin
                it.newer = $urandom; it.older = $urandom;
            end else begin
                it.newer = plausible(order[k]);
                it.older = it.newer + ($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            end
            it.active = $urandom_range(0, 99) < 80;
            it.pin = PIN_NONE;
            send_item(it);
        end
    endtask

    // ratio zero and tensor checks off: a passing cell emits D1 with components 1 to 3 scaled to unit length
    t_stim_row directed_rows [23] = '{
        '{4'd0,  32'sh0123_4567, 32'sh0800_0000, 1'b1, PIN_NONE},
        '{4'd1,  32'sh7FFF_FFFF, 32'sh1000_0000, 1'b1, PIN_NONE},
        '{4'd2,  32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, PIN_NONE},
        '{4'd10, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, PIN_NONE},
        '{4'd2,  32'sh0000_0000, 32'sh0000_0000, 1'b0, PIN_NONE},
        '{4'd3,  32'sh0000_0001, 32'sh0000_0000, 1'b1, PIN_NONE},
        '{4'd4,  32'sh0555_5555, 32'sh0555_5555, 1'b1, PIN_NONE},
        '{4'd5,  32'sh0555_5555, 32'sh0555_5555, 1'b1, PIN_NONE},
        '{4'd6,  32'sh0555_5555, 32'sh0555_5555, 1'b1, PIN_NONE},
        '{4'd7,  32'sh0000_0000, 32'sh0000_0000, 1'b1, PIN_NONE},
        '{4'd8,  32'shFFFF_FFFF, 32'sh0000_0000, 1'b1, PIN_NONE},
        '{4'd15, 32'sh8000_0000, 32'sh8000_0000, 1'b0, PIN_NONE},
        '{4'd9,  32'sh0000_0000, 32'sh0000_0000, 1'b0, PIN_PASS},
        '{4'd9,  32'sh8000_0000, 32'sh8000_0000, 1'b1, PIN_NONE},
        '{4'd8,  32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, PIN_NONE},
        '{4'd7,  32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, PIN_NONE},
        '{4'd6,  32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1, PIN_NONE},
        '{4'd5,  32'sh1000_0000, 32'sh1000_0001, 1'b1, PIN_NONE},
        '{4'd4,  32'sh0000_0000, 32'shF000_0000, 1'b1, PIN_NONE},
        '{4'd3,  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, PIN_NONE},
        '{4'd2,  32'sh8000_0000, 32'sh8000_0000, 1'b1, PIN_NONE},
        '{4'd1,  32'shAAAA_AAAA, 32'sh5555_5555, 1'b1, PIN_NONE},
        '{4'd0,  32'sh0000_0000, 32'sh7FFF_FFFF, 1'b1, PIN_REJ}
    };

    logic [VAL_W-1:0] phase_ratio [6];
    logic             phase_full  [6];

    initial begin
        ratio_q16 = 0;
        full_mode = 1'b0;
        have_mask = '0;
        rejects_seen = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[n]) send_item(directed_rows[n]);
        drain();

        phase_ratio = '{32'h0000_8000, 32'h0000_8000, 32'h7FFF_FFFF,
                        32'h8000_0000, $urandom, 32'h0001_0000};
        phase_full  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_RATIO, phase_ratio[p]);
            write_reg(REG_FULL, phase_full[p] | ($urandom & 32'hFFFF_FFFE));
            calm = (p == 3);
            random_cell();
            drain();
        end

        $display("covered %0d items, %0d cells, %0d results checked over 7 register settings",
                 items_sent, cells_done, emits_checked);
        if (errors == 0) begin
            $display("tensor_extrapolate_realizability_tb: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("tensor_extrapolate_realizability_tb: errors");
        end
        $finish;
    end
endmodule
